// ===== hw/rtl/ep2cal_pkg.sv =====
// Package for the epoch seconds to calendar converter.
// Holds the sequencer state type, the division constants and the month length table.
// No dependencies.
`default_nettype none

package ep2cal_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DAY,
    ST_DAY_REM,
    ST_HOUR,
    ST_HOUR_REM,
    ST_MIN,
    ST_MIN_REM,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_e;

  // Divide by a constant through a reciprocal multiply. Each divisor is an odd part
  // shifted left; drop the shift as low bits, then (x * Recip) >> shift gives the
  // quotient by the odd part, exact over the whole range of x.
  //   days:    86400 = 675 << 7, x below 2^25, shift 35
  //   hours:   3600  = 225 << 4, x below 5400, shift 21
  //   minutes: 60    = 15  << 2, x below 900,  shift 14
  localparam logic [25:0] DayRecip  = 26'd50903317;
  localparam logic [9:0]  DayOdd    = 10'd675;
  localparam logic [13:0] HourRecip = 14'd9321;
  localparam logic [7:0]  HourOdd   = 8'd225;
  localparam logic [10:0] MinRecip  = 11'd1093;
  localparam logic [3:0]  MinOdd    = 4'd15;

  localparam logic [8:0]  DaysCommon  = 9'd365;
  localparam logic [8:0]  DaysLeap    = 9'd366;
  localparam logic [11:0] YearBase    = 12'd1970;

  // Days in a month, month is one-based; leap selects 29 days for February
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/epoch_seconds_to_calendar.sv =====
// Epoch seconds to calendar date and time converter, top level.
// Uses ep2cal_pkg for the state type, constants and month length table.
// A shared multiplier and a subtractor are stepped by a small sequencer.
`default_nettype none

// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into year, month,
// day (one-based), hour, minute and second. Every year divisible by four is
// counted as leap, 2100 included. The sequencer first splits off days, hours,
// minutes and seconds with one shared multiplier (a reciprocal multiply, then
// the remainder, for each unit); the single subtractor then takes off one year
// or one month a cycle. A new item is taken only when the sequencer is idle,
// in the cycle after the previous result is loaded; a finished result waits in
// the output register and does not block the input, but the sequencer holds its
// next result until that register is free.
module epoch_seconds_to_calendar (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] epoch_seconds_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [11:0]      year_o,
  output logic [3:0]       month_o,
  output logic [4:0]       day_o,
  output logic [4:0]       hour_o,
  output logic [5:0]       minute_o,
  output logic [5:0]       second_o
);

  ep2cal_pkg::state_e state_q, state_d;
  logic               out_valid_q, out_valid_d;

  // Working registers
  logic [31:0] num_q, num_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] days_q, days_d;
  logic [11:0] year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  minute_q, minute_d;
  logic [5:0]  second_q, second_d;

  // Output registers
  logic [11:0] year_out_q, year_out_d;
  logic [3:0]  month_out_q, month_out_d;
  logic [4:0]  day_out_q, day_out_d;
  logic [4:0]  hour_out_q, hour_out_d;
  logic [5:0]  minute_out_q, minute_out_d;
  logic [5:0]  second_out_q, second_out_d;

  // Shared multiplier
  logic [24:0] mul_a;
  logic [25:0] mul_b;
  logic [50:0] prod;
  logic [9:0]  day_rem;
  logic [7:0]  hour_rem;
  logic [3:0]  min_rem;

  // Year and month subtractor
  logic [8:0]  op_b;
  logic [16:0] diff;
  logic        borrow;
  logic        leap;
  logic [8:0]  year_len;
  logic        out_free;

  assign leap     = (year_q[1:0] == 2'b00);
  assign year_len = leap ? ep2cal_pkg::DaysLeap : ep2cal_pkg::DaysCommon;

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = num_q[31:7];
    mul_b = ep2cal_pkg::DayRecip;
    unique case (state_q)
      ep2cal_pkg::ST_DAY_REM: begin
        mul_a = {9'd0, days_q};
        mul_b = {16'd0, ep2cal_pkg::DayOdd};
      end
      ep2cal_pkg::ST_HOUR: begin
        mul_a = {12'd0, rem_q[16:4]};
        mul_b = {12'd0, ep2cal_pkg::HourRecip};
      end
      ep2cal_pkg::ST_HOUR_REM: begin
        mul_a = {20'd0, hour_q};
        mul_b = {18'd0, ep2cal_pkg::HourOdd};
      end
      ep2cal_pkg::ST_MIN: begin
        mul_a = {15'd0, rem_q[11:2]};
        mul_b = {15'd0, ep2cal_pkg::MinRecip};
      end
      ep2cal_pkg::ST_MIN_REM: begin
        mul_a = {19'd0, minute_q};
        mul_b = {22'd0, ep2cal_pkg::MinOdd};
      end
      default: begin
        mul_a = num_q[31:7];
        mul_b = ep2cal_pkg::DayRecip;
      end
    endcase
  end

  assign prod = {26'd0, mul_a} * {25'd0, mul_b};

  // Remainders are below the odd divisor, so only their low bits are needed
  assign day_rem  = num_q[16:7] - prod[9:0];
  assign hour_rem = rem_q[11:4] - prod[7:0];
  assign min_rem  = rem_q[5:2] - prod[3:0];

  // Take off a year or a month when it fits
  assign op_b   = (state_q == ep2cal_pkg::ST_YEAR) ? year_len
                                                   : {4'd0, ep2cal_pkg::month_len(month_q, leap)};
  assign diff   = {1'b0, days_q} - {8'd0, op_b};
  assign borrow = diff[16];

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ep2cal_pkg::ST_IDLE);

  // Sequencer: next state and working register updates
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q;
    num_d        = num_q;
    rem_d        = rem_q;
    days_d       = days_q;
    year_d       = year_q;
    month_d      = month_q;
    hour_d       = hour_q;
    minute_d     = minute_q;
    second_d     = second_q;
    year_out_d   = year_out_q;
    month_out_d  = month_out_q;
    day_out_d    = day_out_q;
    hour_out_d   = hour_out_q;
    minute_out_d = minute_out_q;
    second_out_d = second_out_q;

    // Drop the result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ep2cal_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          num_d   = epoch_seconds_i;
          state_d = ep2cal_pkg::ST_DAY;
        end
      end
      ep2cal_pkg::ST_DAY: begin
        // Whole days
        days_d  = prod[50:35];
        state_d = ep2cal_pkg::ST_DAY_REM;
      end
      ep2cal_pkg::ST_DAY_REM: begin
        // Seconds of the day
        rem_d   = {day_rem, num_q[6:0]};
        state_d = ep2cal_pkg::ST_HOUR;
      end
      ep2cal_pkg::ST_HOUR: begin
        hour_d  = prod[25:21];
        state_d = ep2cal_pkg::ST_HOUR_REM;
      end
      ep2cal_pkg::ST_HOUR_REM: begin
        // Seconds of the hour
        rem_d   = {5'd0, hour_rem, rem_q[3:0]};
        state_d = ep2cal_pkg::ST_MIN;
      end
      ep2cal_pkg::ST_MIN: begin
        minute_d = prod[19:14];
        state_d  = ep2cal_pkg::ST_MIN_REM;
      end
      ep2cal_pkg::ST_MIN_REM: begin
        second_d = {min_rem, rem_q[1:0]};
        year_d   = ep2cal_pkg::YearBase;
        month_d  = 4'd1;
        state_d  = ep2cal_pkg::ST_YEAR;
      end
      ep2cal_pkg::ST_YEAR: begin
        // Take off one whole year a cycle
        if (borrow) begin
          state_d = ep2cal_pkg::ST_MONTH;
        end else begin
          days_d = diff[15:0];
          year_d = year_q + 12'd1;
        end
      end
      ep2cal_pkg::ST_MONTH: begin
        // Take off one whole month a cycle
        if (borrow) begin
          state_d = ep2cal_pkg::ST_DONE;
        end else begin
          days_d  = diff[15:0];
          month_d = month_q + 4'd1;
        end
      end
      ep2cal_pkg::ST_DONE: begin
        // Hold until the output register is free
        if (out_free) begin
          year_out_d   = year_q;
          month_out_d  = month_q;
          day_out_d    = days_q[4:0] + 5'd1;
          hour_out_d   = hour_q;
          minute_out_d = minute_q;
          second_out_d = second_q;
          out_valid_d  = 1'b1;
          state_d      = ep2cal_pkg::ST_IDLE;
        end
      end
      default: state_d = ep2cal_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ep2cal_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    num_q        <= num_d;
    rem_q        <= rem_d;
    days_q       <= days_d;
    year_q       <= year_d;
    month_q      <= month_d;
    hour_q       <= hour_d;
    minute_q     <= minute_d;
    second_q     <= second_d;
    year_out_q   <= year_out_d;
    month_out_q  <= month_out_d;
    day_out_q    <= day_out_d;
    hour_out_q   <= hour_out_d;
    minute_out_q <= minute_out_d;
    second_out_q <= second_out_d;
  end

  assign out_valid_o = out_valid_q;
  assign year_o      = year_out_q;
  assign month_o     = month_out_q;
  assign day_o       = day_out_q;
  assign hour_o      = hour_out_q;
  assign minute_o    = minute_out_q;
  assign second_o    = second_out_q;

endmodule

`default_nettype wire
